// ===== rtl/agl_pkg.sv =====
// Shared types and constants of the adaptive gravity low-pass filter.
// Used by agl_ctrl, agl_dpath and adaptive_gravity_lowpass; depends on nothing.
`default_nettype none

package agl_pkg;

	localparam int GRAV_W  = 15;
	localparam int TAU_W   = 17;
	localparam int LIM_W   = 16;
	localparam int CFG_W   = 17;
	localparam int CFG_A_W = 3;
	localparam int TIME_W  = 64;
	localparam int ACCY_W  = 3;
	localparam int DIV_W   = 64;

	localparam logic [19:0] US_PER_S = 20'd1000000;

	localparam logic [CFG_A_W-1:0] CFG_GRAVITY_LEVEL  = 3'd0;
	localparam logic [CFG_A_W-1:0] CFG_TAU_LOW        = 3'd1;
	localparam logic [CFG_A_W-1:0] CFG_TAU_MID        = 3'd2;
	localparam logic [CFG_A_W-1:0] CFG_TAU_HIGH       = 3'd3;
	localparam logic [CFG_A_W-1:0] CFG_ERR_LOW_LIMIT  = 3'd4;
	localparam logic [CFG_A_W-1:0] CFG_ERR_HIGH_LIMIT = 3'd5;

	localparam logic [GRAV_W-1:0] GRAVITY_LEVEL_RST  = 15'd10042;
	localparam logic [TAU_W-1:0]  TAU_LOW_RST        = 17'd26214;
	localparam logic [TAU_W-1:0]  TAU_MID_RST        = 17'd49152;
	localparam logic [TAU_W-1:0]  TAU_HIGH_RST       = 17'd64881;
	localparam logic [LIM_W-1:0]  ERR_LOW_LIMIT_RST  = 16'd6554;
	localparam logic [LIM_W-1:0]  ERR_HIGH_LIMIT_RST = 16'd58982;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_SQ_MUL,
		S_SQ_ACC,
		S_SQRT,
		S_SQRT_WAIT,
		S_SC_MUL,
		S_SC_DIV,
		S_SC_WAIT,
		S_SC_WB,
		S_ERR,
		S_ERR_WAIT,
		S_ERR_WB,
		S_TAU_MUL,
		S_ALPHA_DEN,
		S_ALPHA_DIV,
		S_ALPHA_WAIT,
		S_ALPHA_WB,
		S_BL_MUL_E,
		S_BL_ACC_E,
		S_BL_MUL_S,
		S_BL_ACC_S,
		S_BL_RND,
		S_BL_CHK,
		S_COMMIT,
		S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_MUL,
		OP_SQ_ACC,
		OP_SQRT_START,
		OP_SC_MUL,
		OP_SC_DIV,
		OP_SC_WB,
		OP_ERR_DIV,
		OP_ERR_SAT,
		OP_ERR_WB,
		OP_TAU_MUL,
		OP_ALPHA_DEN,
		OP_ALPHA_DIV,
		OP_ALPHA_ONE,
		OP_ALPHA_WB,
		OP_BL_MUL_E,
		OP_BL_ACC_E,
		OP_BL_MUL_S,
		OP_BL_ACC_S,
		OP_BL_RND,
		OP_COMMIT,
		OP_OUTPUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
		logic       vsel;
	} cmd_t;

	typedef struct packed {
		logic zero_in;
		logic have_prev;
		logic g_zero;
		logic den_zero;
		logic b_zero;
		logic busy;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/agl_ctrl.sv =====
// Controller of the adaptive gravity low-pass filter: sequences the datapath.
// Depends on agl_pkg for the state, command and status types.
`default_nettype none

module agl_ctrl
	import agl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output cmd_t         cmd,
	input  wire status_t status
);

	state_t     state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic       vsel_q, vsel_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= 2'd0;
			vsel_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			vsel_q      <= vsel_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		vsel_d      = vsel_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd.op      = OP_NONE;
		cmd.idx     = idx_q;
		cmd.vsel    = vsel_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					idx_d   = 2'd0;
					vsel_d  = 1'b0;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = status.zero_in ? S_OUT : S_SQ_MUL;
			end
			S_SQ_MUL: begin
				cmd.op  = OP_SQ_MUL;
				state_d = S_SQ_ACC;
			end
			S_SQ_ACC: begin
				cmd.op = OP_SQ_ACC;
				if (idx_q == 2'd2) begin
					state_d = S_SQRT;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_SQ_MUL;
				end
			end
			S_SQRT: begin
				cmd.op  = OP_SQRT_START;
				state_d = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: begin
				if (!status.busy) begin
					idx_d   = 2'd0;
					state_d = S_SC_MUL;
				end
			end
			S_SC_MUL: begin
				cmd.op  = OP_SC_MUL;
				state_d = S_SC_DIV;
			end
			S_SC_DIV: begin
				cmd.op  = OP_SC_DIV;
				state_d = S_SC_WAIT;
			end
			S_SC_WAIT: begin
				if (!status.busy) begin
					state_d = S_SC_WB;
				end
			end
			S_SC_WB: begin
				cmd.op = OP_SC_WB;
				if (idx_q == 2'd2) begin
					state_d = (vsel_q || !status.have_prev) ? S_COMMIT : S_ERR;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_SC_MUL;
				end
			end
			S_ERR: begin
				if (status.g_zero) begin
					cmd.op  = OP_ERR_SAT;
					state_d = S_TAU_MUL;
				end else begin
					cmd.op  = OP_ERR_DIV;
					state_d = S_ERR_WAIT;
				end
			end
			S_ERR_WAIT: begin
				if (!status.busy) begin
					state_d = S_ERR_WB;
				end
			end
			S_ERR_WB: begin
				cmd.op  = OP_ERR_WB;
				state_d = S_TAU_MUL;
			end
			S_TAU_MUL: begin
				cmd.op  = OP_TAU_MUL;
				state_d = S_ALPHA_DEN;
			end
			S_ALPHA_DEN: begin
				cmd.op  = OP_ALPHA_DEN;
				state_d = S_ALPHA_DIV;
			end
			S_ALPHA_DIV: begin
				idx_d = 2'd0;
				if (status.den_zero) begin
					cmd.op  = OP_ALPHA_ONE;
					state_d = S_BL_MUL_E;
				end else begin
					cmd.op  = OP_ALPHA_DIV;
					state_d = S_ALPHA_WAIT;
				end
			end
			S_ALPHA_WAIT: begin
				if (!status.busy) begin
					state_d = S_ALPHA_WB;
				end
			end
			S_ALPHA_WB: begin
				cmd.op  = OP_ALPHA_WB;
				state_d = S_BL_MUL_E;
			end
			S_BL_MUL_E: begin
				cmd.op  = OP_BL_MUL_E;
				state_d = S_BL_ACC_E;
			end
			S_BL_ACC_E: begin
				cmd.op  = OP_BL_ACC_E;
				state_d = S_BL_MUL_S;
			end
			S_BL_MUL_S: begin
				cmd.op  = OP_BL_MUL_S;
				state_d = S_BL_ACC_S;
			end
			S_BL_ACC_S: begin
				cmd.op  = OP_BL_ACC_S;
				state_d = S_BL_RND;
			end
			S_BL_RND: begin
				cmd.op = OP_BL_RND;
				if (idx_q == 2'd2) begin
					state_d = S_BL_CHK;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_BL_MUL_E;
				end
			end
			S_BL_CHK: begin
				if (status.b_zero) begin
					state_d = S_COMMIT;
				end else begin
					idx_d   = 2'd0;
					vsel_d  = 1'b1;
					state_d = S_SQ_MUL;
				end
			end
			S_COMMIT: begin
				cmd.op  = OP_COMMIT;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_OUTPUT;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/agl_dpath.sv =====
// Datapath of the adaptive gravity low-pass filter: configuration and state
// registers, one shared multiplier, a bit-serial divider and square root.
// Depends on agl_pkg; driven by commands from agl_ctrl.
`default_nettype none

module agl_dpath
	import agl_pkg::*;
#(
	parameter int ACCEL_WIDTH    = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_A_W-1:0]            cfg_addr,
	input  wire logic [CFG_W-1:0]              cfg_wdata,
	input  wire logic signed [ACCEL_WIDTH-1:0] accel_x,
	input  wire logic signed [ACCEL_WIDTH-1:0] accel_y,
	input  wire logic signed [ACCEL_WIDTH-1:0] accel_z,
	input  wire logic [TIME_W-1:0]             sample_time,
	input  wire logic signed [ACCY_W-1:0]      sample_accuracy,
	input  wire cmd_t                          cmd,
	output status_t                            status,
	output logic signed [ACCEL_WIDTH-1:0]      grav_x,
	output logic signed [ACCEL_WIDTH-1:0]      grav_y,
	output logic signed [ACCEL_WIDTH-1:0]      grav_z,
	output logic [TIME_W-1:0]                  estimate_time,
	output logic signed [ACCY_W-1:0]           estimate_accuracy,
	output logic                               zero_input
);

	localparam int AW    = ACCEL_WIDTH;
	localparam int F     = COEF_FRAC_BITS;
	localparam int MW    = (AW + 1 > F + 2) ? ((AW + 1 > 21) ? AW + 1 : 21)
	                                        : ((F + 2 > 21) ? F + 2 : 21);
	localparam int PW    = 2 * MW;
	localparam int TW    = PW + 1;
	localparam int SUMW  = 2 * AW;
	localparam int DMW   = (AW > GRAV_W) ? AW : GRAV_W;
	localparam int EW    = DMW + F;
	localparam int QS    = 16;
	localparam int CNTW  = $clog2(EW + 1);

	// Configuration registers.
	logic [GRAV_W-1:0] grav_lvl_q;
	logic [TAU_W-1:0]  tau_low_q, tau_mid_q, tau_high_q;
	logic [LIM_W-1:0]  lim_low_q, lim_high_q;

	// Filter state.
	logic signed [AW-1:0] est_q [3];
	logic [TIME_W-1:0]    last_time_q;
	logic [ACCY_W-1:0]    last_acc_q;

	// Working registers.
	logic signed [AW-1:0] a_q [3];
	logic signed [AW:0]   b_q [3];
	logic signed [AW-1:0] s_q [3];
	logic [TIME_W-1:0]    time_in_q;
	logic [ACCY_W-1:0]    acc_in_q;
	logic                 zero_q;
	logic signed [PW-1:0] prod_q;
	logic [SUMW-1:0]      sum_q;
	logic [AW-1:0]        n_q;
	logic [TAU_W-1:0]     tau_q;
	logic [F:0]           alpha_q;
	logic [DIV_W-1:0]     tm_q, den_q;
	logic signed [TW-1:0] t_q;

	// Iterative unit.
	logic                 busy_q;
	logic                 sqrt_mode_q;
	logic [CNTW-1:0]      cnt_q;
	logic [DIV_W-1:0]     rem_q, sh_q, dv_den_q;
	logic [AW+1:0]        sq_rem_q;
	logic [SUMW-1:0]      sq_v_q;

	// Output registers.
	logic signed [AW-1:0] out_g_q [3];
	logic [TIME_W-1:0]    out_time_q;
	logic [ACCY_W-1:0]    out_acc_q;
	logic                 out_zero_q;

	logic signed [AW:0]   src;
	logic [AW:0]          src_mag;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p;
	logic                 dv_start;
	logic [DIV_W-1:0]     dv_num, dv_den;
	logic [CNTW-1:0]      dv_q;
	logic [DIV_W:0]       dv_t;
	logic                 dv_ge;
	logic [AW+3:0]        sq_r, sq_trial;
	logic                 sq_ge;
	logic [DMW:0]         diff;
	logic [TIME_W-1:0]    dt_full;
	logic [31:0]          dt32;
	logic [32:0]          sc_q, sc_lim, sc_sat, sc_val;
	logic [EW-1:0]        err;
	logic [TAU_W-1:0]     tau_sel;
	logic [TW-1:0]        t_mag, t_rnd;
	logic [AW:0]          b_new;

	assign src     = cmd.vsel ? b_q[cmd.idx] : (AW + 1)'(a_q[cmd.idx]);
	assign src_mag = src[AW] ? (AW + 1)'(-src) : (AW + 1)'(src);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ_MUL: begin
				mul_a = MW'(src);
				mul_b = MW'(src);
			end
			OP_SC_MUL: begin
				mul_a = MW'(src_mag);
				mul_b = MW'(grav_lvl_q);
			end
			OP_TAU_MUL: begin
				mul_a = MW'(tau_q);
				mul_b = MW'(US_PER_S);
			end
			OP_BL_MUL_E: begin
				mul_a = MW'(alpha_q);
				mul_b = MW'(est_q[cmd.idx]);
			end
			OP_BL_MUL_S: begin
				mul_a = MW'((F + 1)'(1) << F) - MW'(alpha_q);
				mul_b = MW'(s_q[cmd.idx]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign diff = (DMW'(n_q) > DMW'(grav_lvl_q)) ? (DMW + 1)'(DMW'(n_q) - DMW'(grav_lvl_q))
	                                            : (DMW + 1)'(DMW'(grav_lvl_q) - DMW'(n_q));

	always_comb begin
		dv_start = 1'b0;
		dv_num   = '0;
		dv_den   = '0;
		dv_q     = '0;
		case (cmd.op)
			OP_SC_DIV: begin
				dv_start = 1'b1;
				dv_num   = (DIV_W'(prod_q) << 1) + DIV_W'(n_q);
				dv_den   = DIV_W'(n_q) << 1;
				dv_q     = CNTW'(QS);
			end
			OP_ERR_DIV: begin
				dv_start = 1'b1;
				dv_num   = DIV_W'(diff) << F;
				dv_den   = DIV_W'(grav_lvl_q);
				dv_q     = CNTW'(EW);
			end
			OP_ALPHA_DIV: begin
				dv_start = 1'b1;
				dv_num   = (tm_q << F) + (den_q >> 1);
				dv_den   = den_q;
				dv_q     = CNTW'(F + 1);
			end
			default: begin
				dv_start = 1'b0;
			end
		endcase
	end

	assign dv_t     = {rem_q, sh_q[DIV_W-1]};
	assign dv_ge    = dv_t >= {1'b0, dv_den_q};
	assign sq_r     = {sq_rem_q, sq_v_q[SUMW-1 -: 2]};
	assign sq_trial = {2'b00, n_q, 2'b01};
	assign sq_ge    = sq_r >= sq_trial;

	assign dt_full = time_in_q - last_time_q;
	assign dt32    = (dt_full[TIME_W-1:32] != '0) ? 32'hFFFF_FFFF : dt_full[31:0];

	assign sc_q   = 33'(sh_q[QS-1:0]);
	assign sc_lim = src[AW] ? (33'(1) << (AW - 1)) : ((33'(1) << (AW - 1)) - 33'd1);
	assign sc_sat = (sc_q > sc_lim) ? sc_lim : sc_q;
	assign sc_val = src[AW] ? -sc_sat : sc_sat;

	assign err     = sh_q[EW-1:0];
	assign tau_sel = (err < EW'(lim_low_q)) ? tau_low_q
	               : ((err > EW'(lim_high_q)) ? tau_high_q : tau_mid_q);

	assign t_mag = t_q[TW-1] ? TW'(-t_q) : TW'(t_q);
	assign t_rnd = (t_mag + (TW'(1) << (F - 1))) >> F;
	assign b_new = t_q[TW-1] ? (AW + 1)'(-t_rnd) : (AW + 1)'(t_rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_lvl_q  <= GRAVITY_LEVEL_RST;
			tau_low_q   <= TAU_LOW_RST;
			tau_mid_q   <= TAU_MID_RST;
			tau_high_q  <= TAU_HIGH_RST;
			lim_low_q   <= ERR_LOW_LIMIT_RST;
			lim_high_q  <= ERR_HIGH_LIMIT_RST;
			for (int i = 0; i < 3; i++) begin
				est_q[i] <= '1;
			end
			last_time_q <= '0;
			last_acc_q  <= '1;
			busy_q      <= 1'b0;
			sqrt_mode_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_GRAVITY_LEVEL:  grav_lvl_q <= cfg_wdata[GRAV_W-1:0];
					CFG_TAU_LOW:        tau_low_q  <= cfg_wdata[TAU_W-1:0];
					CFG_TAU_MID:        tau_mid_q  <= cfg_wdata[TAU_W-1:0];
					CFG_TAU_HIGH:       tau_high_q <= cfg_wdata[TAU_W-1:0];
					CFG_ERR_LOW_LIMIT:  lim_low_q  <= cfg_wdata[LIM_W-1:0];
					CFG_ERR_HIGH_LIMIT: lim_high_q <= cfg_wdata[LIM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_COMMIT) begin
				for (int i = 0; i < 3; i++) begin
					est_q[i] <= s_q[i];
				end
				last_time_q <= time_in_q;
				last_acc_q  <= acc_in_q;
			end
			if (cmd.op == OP_SQRT_START) begin
				busy_q      <= 1'b1;
				sqrt_mode_q <= 1'b1;
				cnt_q       <= CNTW'(AW);
			end else if (dv_start) begin
				busy_q      <= 1'b1;
				sqrt_mode_q <= 1'b0;
				cnt_q       <= dv_q;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (cmd.op)
			OP_LOAD: begin
				a_q[0]    <= accel_x;
				a_q[1]    <= accel_y;
				a_q[2]    <= accel_z;
				time_in_q <= sample_time;
				acc_in_q  <= sample_accuracy;
				zero_q    <= (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
			end
			OP_SQ_ACC: begin
				sum_q <= ((cmd.idx == 2'd0) ? '0 : sum_q) + SUMW'(prod_q);
			end
			OP_SC_WB: begin
				s_q[cmd.idx] <= AW'(sc_val);
			end
			OP_ERR_SAT: begin
				tau_q <= tau_high_q;
			end
			OP_ERR_WB: begin
				tau_q <= tau_sel;
			end
			OP_ALPHA_DEN: begin
				tm_q  <= DIV_W'(prod_q);
				den_q <= DIV_W'(prod_q) + (DIV_W'(dt32) << F);
			end
			OP_ALPHA_ONE: begin
				alpha_q <= (F + 1)'(1) << F;
			end
			OP_ALPHA_WB: begin
				alpha_q <= sh_q[F:0];
			end
			OP_BL_ACC_E: begin
				t_q <= TW'(prod_q);
			end
			OP_BL_ACC_S: begin
				t_q <= t_q + TW'(prod_q);
			end
			OP_BL_RND: begin
				b_q[cmd.idx] <= b_new;
			end
			OP_OUTPUT: begin
				for (int i = 0; i < 3; i++) begin
					out_g_q[i] <= est_q[i];
				end
				out_time_q <= last_time_q;
				out_acc_q  <= last_acc_q;
				out_zero_q <= zero_q;
			end
			default: ;
		endcase

		if (cmd.op == OP_SQRT_START) begin
			sq_v_q   <= sum_q;
			sq_rem_q <= '0;
			n_q      <= '0;
		end else if (busy_q && sqrt_mode_q) begin
			sq_v_q   <= sq_v_q << 2;
			sq_rem_q <= sq_ge ? (AW + 2)'(sq_r - sq_trial) : (AW + 2)'(sq_r);
			n_q      <= {n_q[AW-2:0], sq_ge};
		end

		if (dv_start) begin
			rem_q    <= dv_num >> dv_q;
			sh_q     <= dv_num << (CNTW'(DIV_W) - dv_q);
			dv_den_q <= dv_den;
		end else if (busy_q && !sqrt_mode_q) begin
			rem_q <= dv_ge ? DIV_W'(dv_t - {1'b0, dv_den_q}) : dv_t[DIV_W-1:0];
			sh_q  <= {sh_q[DIV_W-2:0], dv_ge};
		end
	end

	assign status.zero_in   = zero_q;
	assign status.have_prev = last_time_q != '0;
	assign status.g_zero    = grav_lvl_q == '0;
	assign status.den_zero  = den_q == '0;
	assign status.b_zero    = (b_q[0] == '0) && (b_q[1] == '0) && (b_q[2] == '0);
	assign status.busy      = busy_q;

	assign grav_x            = out_g_q[0];
	assign grav_y            = out_g_q[1];
	assign grav_z            = out_g_q[2];
	assign estimate_time     = out_time_q;
	assign estimate_accuracy = out_acc_q;
	assign zero_input        = out_zero_q;

endmodule

`default_nettype wire

// ===== rtl/adaptive_gravity_lowpass.sv =====
// Top level of the adaptive gravity low-pass filter.
// Instantiates agl_ctrl and agl_dpath; depends on agl_pkg.
//
// Each accepted accelerometer beat is normalized to the gravity level, blended
// with the stored estimate using a time constant chosen from the length error,
// renormalized and returned as one result beat. One sample is processed at a
// time. The sequence uses the shared one-bit-per-cycle divider (eight
// divisions) and square root (two roots). A zero sample, the first sample
// after reset or a zero gravity level finishes sooner. A new sample is taken
// as soon as the previous one is done, even while its result still waits in
// the output register.
`default_nettype none

module adaptive_gravity_lowpass
	import agl_pkg::*;
#(
	parameter int ACCEL_WIDTH    = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_A_W-1:0]            cfg_addr,
	input  wire logic [CFG_W-1:0]              cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [ACCEL_WIDTH-1:0] accel_x,
	input  wire logic signed [ACCEL_WIDTH-1:0] accel_y,
	input  wire logic signed [ACCEL_WIDTH-1:0] accel_z,
	input  wire logic [TIME_W-1:0]             sample_time,
	input  wire logic signed [ACCY_W-1:0]      sample_accuracy,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [ACCEL_WIDTH-1:0]      grav_x,
	output logic signed [ACCEL_WIDTH-1:0]      grav_y,
	output logic signed [ACCEL_WIDTH-1:0]      grav_z,
	output logic [TIME_W-1:0]                  estimate_time,
	output logic signed [ACCY_W-1:0]           estimate_accuracy,
	output logic                               zero_input
);

	cmd_t    cmd;
	status_t status;

	agl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	agl_dpath #(
		.ACCEL_WIDTH    (ACCEL_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_addr          (cfg_addr),
		.cfg_wdata         (cfg_wdata),
		.accel_x           (accel_x),
		.accel_y           (accel_y),
		.accel_z           (accel_z),
		.sample_time       (sample_time),
		.sample_accuracy   (sample_accuracy),
		.cmd               (cmd),
		.status            (status),
		.grav_x            (grav_x),
		.grav_y            (grav_y),
		.grav_z            (grav_z),
		.estimate_time     (estimate_time),
		.estimate_accuracy (estimate_accuracy),
		.zero_input        (zero_input)
	);

endmodule

`default_nettype wire
